// ===== src/isc_pkg.sv =====
// Shared types, sizes and helper functions of the itemset support counter.
package isc_pkg;

    localparam int ITEMS       = 8;
    localparam int COUNT_BITS  = 16;
    localparam int TABLE_DEPTH = 1 << ITEMS;
    localparam int MASK_IN_W   = 8;
    localparam int MASK_W      = (ITEMS > MASK_IN_W) ? ITEMS : MASK_IN_W;
    localparam int OUT_W       = 16;
    localparam int CFG_W       = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX     = {COUNT_BITS{1'b1}};
    localparam logic [OUT_W-1:0]      OUT_COUNT_MAX = {OUT_W{1'b1}};
    localparam logic [CFG_W-1:0]      MIN_SUPPORT_RESET = CFG_W'(2);

    localparam logic ACTION_ADD   = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [MASK_IN_W-1:0] item_mask;
    } in_item_t;

    typedef struct packed {
        logic [OUT_W-1:0] support_count;
        logic             frequent;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic walk;
        logic query_rd;
        logic out_load;
    } isc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_query;
        logic mask_zero;
        logic sub_last;
        logic out_free;
    } isc_status_t;

    // Clamps a counter value to the width of the result field.
    function automatic logic [OUT_W-1:0] clamp_count(input logic [COUNT_BITS-1:0] c);
        logic [31:0] w;
        w = 32'(c);
        if (w > 32'(OUT_COUNT_MAX)) begin
            return OUT_COUNT_MAX;
        end
        return w[OUT_W-1:0];
    endfunction

    // Adds one to a counter, holding it at its maximum.
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        if (c == COUNT_MAX) begin
            return c;
        end
        return c + COUNT_BITS'(1);
    endfunction

endpackage

// ===== src/isc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module isc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/isc_ctrl.sv =====
// Sequencer that steps the datapath through transaction walks and queries.
module isc_ctrl
    import isc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  isc_status_t status,
    output isc_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_QREAD = 4'b0100,
        ST_QDONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load = 1'b1;
                    if (status.is_query) begin
                        state_next = ST_QREAD;
                    end else if (!status.mask_zero) begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                cmd.walk = 1'b1;
                if (status.sub_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_QREAD: begin
                cmd.query_rd = 1'b1;
                state_next   = ST_QDONE;
            end
            ST_QDONE: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/isc_datapath.sv =====
// Counter memory, subset walker, read-modify-write pipe and result register.
module isc_datapath
    import isc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  in_item_t         s_data,
    input  logic             cfg_valid,
    input  logic [CFG_W-1:0] cfg_data,
    output out_item_t        m_data,
    output logic             m_valid,
    input  logic             m_ready,
    input  isc_cmd_t         cmd,
    output isc_status_t      status
);

    logic [ITEMS-1:0]       mask_reg;
    logic [ITEMS-1:0]       sub_reg;
    logic [ITEMS-1:0]       wr_addr_reg;
    logic                   wr_pend_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic                   qvalid_reg;
    logic [CFG_W-1:0]       min_support_reg;
    logic                   m_valid_reg;
    out_item_t              m_data_reg;

    logic [MASK_W-1:0]      in_wide;
    logic [ITEMS-1:0]       in_mask;
    logic [ITEMS-1:0]       sub_step;
    logic [ITEMS-1:0]       rd_addr;
    logic                   rd_en;
    logic [COUNT_BITS-1:0]  rdata;
    logic [COUNT_BITS-1:0]  old_count;
    logic [COUNT_BITS-1:0]  q_count;

    // Mask bits above the item count are dropped.
    assign in_wide  = MASK_W'(s_data.item_mask);
    assign in_mask  = in_wide[ITEMS-1:0];
    assign sub_step = (sub_reg - ITEMS'(1)) & mask_reg;

    assign rd_en   = cmd.walk | cmd.query_rd;
    assign rd_addr = cmd.walk ? sub_reg : mask_reg;

    // An entry that was never written counts as zero.
    assign old_count = valid_reg[wr_addr_reg] ? rdata : '0;
    assign q_count   = qvalid_reg ? rdata : '0;

    isc_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (wr_pend_reg),
        .waddr (wr_addr_reg),
        .wdata (sat_inc(old_count)),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            mask_reg <= in_mask;
            sub_reg  <= in_mask;
        end else if (cmd.walk) begin
            sub_reg <= sub_step;
        end
        wr_addr_reg <= sub_reg;
        if (cmd.query_rd) begin
            qvalid_reg <= valid_reg[mask_reg];
        end
        if (cmd.out_load) begin
            m_data_reg.support_count <= clamp_count(q_count);
            m_data_reg.frequent      <= (32'(q_count) >= 32'(min_support_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pend_reg     <= 1'b0;
            valid_reg       <= '0;
            min_support_reg <= MIN_SUPPORT_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            wr_pend_reg <= cmd.walk;
            if (wr_pend_reg) begin
                valid_reg[wr_addr_reg] <= 1'b1;
            end
            if (cfg_valid) begin
                min_support_reg <= cfg_data;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.is_query  = (s_data.action == ACTION_QUERY);
    assign status.mask_zero = (in_mask == '0);
    assign status.sub_last  = (sub_step == '0);
    assign status.out_free  = !m_valid_reg || m_ready;

    a_walk_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk |-> (sub_reg != '0))
        else $error("subset walk reached the empty itemset");

    a_query_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.query_rd |-> !wr_pend_reg)
        else $error("query read overlaps a counter write");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !cmd.out_load)
        else $error("result register overwritten before it was taken");

    a_write_follows_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk |=> (wr_pend_reg && wr_addr_reg == $past(sub_reg)))
        else $error("walk read not followed by its counter write");

endmodule

// ===== src/itemset_support_counter_core.sv =====
// Top level of the itemset support counter: controller, datapath and ports.
//
// The block keeps one saturating support counter for every itemset over the
// configured number of items. Each input transaction on the s_ channel carries
// an action and an item mask. An add action increments the counter of every
// nonempty subset of the mask and produces no result. A query action produces
// one result on the m_ channel: the count of the named itemset, clamped to
// the result width, and a flag that says whether it reaches min_support.
//
// During an add the subset walk issues one read-modify-write of the counter
// memory per cycle, one for each nonempty subset of the mask. A query reads
// its counter in the read state and loads the output register in the done
// state, which waits until the register is free. One transaction is in
// work at a time; s_ready is high only while the sequencer is idle.
//
// The output register holds a result until the receiver takes it. While it
// waits, add transactions are still accepted; a following query finishes its
// read and then holds until the register is free.
//
// Reset clears all counters at once through per-entry valid flags, so no
// clearing pass is needed, and sets min_support to 2. The cfg_ channel is
// always ready and writes min_support; it is meant to be used while idle.
module itemset_support_counter_core
    import isc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_item_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_item_t        m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    isc_cmd_t    cmd;
    isc_status_t status;

    // The configuration register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    isc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    isc_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the itemset support counter core.
`timescale 1ns / 1ps

module testbench;
    import isc_pkg::*;

    // Cycles without any accepted transaction before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 5000;
    // A full eight-item subset walk plus a margin for control overhead.
    localparam int DRAIN_CYCLES   = 300;
    // Length of the deliberate receiver hold-off in the back-pressure test.
    localparam int LONG_HOLD      = 300;
    // Adds of one itemset, enough to carry its counter well past small thresholds.
    localparam int REPEAT_ADDS    = 150;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    in_item_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_item_t        m_data;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data;

    // Mirror of the block's counter memory and its threshold register.
    logic [COUNT_BITS-1:0] support_mirror [TABLE_DEPTH];
    logic [CFG_W-1:0]      min_support_mirror;

    // Query results in the order the block must return them.
    out_item_t expected_results [$];

    // Recently added masks, so that most queries hit counters with history.
    logic [MASK_IN_W-1:0] recent_add_masks [8];

    int  error_count;
    int  quiet_cycles;
    bit  tx_idle_enable;
    bit  rx_idle_enable;
    bit  long_hold_request;

    itemset_support_counter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Adds one to every nonempty subset of the mask, holding at the maximum.
    function automatic void count_transaction(input logic [MASK_IN_W-1:0] mask);
        int unsigned items;
        int unsigned sub;
        items = int'(mask) & (TABLE_DEPTH - 1);
        sub = items;
        while (sub != 0) begin
            if (support_mirror[sub] != {COUNT_BITS{1'b1}}) begin
                support_mirror[sub] = support_mirror[sub] + 1'b1;
            end
            sub = (sub - 1) & items;
        end
    endfunction

    // Works out what a query of the given itemset must return.
    function automatic out_item_t predict_support(input logic [MASK_IN_W-1:0] mask);
        int unsigned      items;
        longint unsigned  count;
        out_item_t        res;
        items = int'(mask) & (TABLE_DEPTH - 1);
        count = (items != 0) ? longint'(support_mirror[items]) : 0;
        res.support_count = (count > 64'hFFFF) ? {OUT_W{1'b1}} : OUT_W'(count);
        res.frequent      = (count >= longint'(min_support_mirror));
        return res;
    endfunction

    // Offers one transaction and waits until the block takes it. Valid is left
    // high so that a following item can go out on the very next cycle.
    task automatic send_item(input logic action, input logic [MASK_IN_W-1:0] mask);
        in_item_t item;
        item.action    = action;
        item.item_mask = mask;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (action == ACTION_QUERY) begin
            expected_results = {expected_results, predict_support(mask)};
        end else begin
            count_transaction(mask);
        end
    endtask

    // A random gap in the sender's offers, when idling is enabled.
    task automatic sender_gap();
        int n;
        if (tx_idle_enable && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 5);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    endtask

    // Stops offering, waits for every pending result and then for the longest
    // subset walk, since an add leaves nothing behind to wait on.
    task automatic settle_block();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_min_support(input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        min_support_mirror = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly sparse masks keep subset walks short; now and then a dense one.
    function automatic logic [MASK_IN_W-1:0] pick_add_mask();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            return MASK_IN_W'($urandom);
        end else if (sel < 5) begin
            return MASK_IN_W'($urandom & $urandom);
        end
        return MASK_IN_W'($urandom & $urandom & $urandom);
    endfunction

    // Freshly reset counters read zero and fail the default threshold of two.
    task automatic test_reset_state();
        send_item(ACTION_QUERY, 8'h00);
        send_item(ACTION_QUERY, 8'hFF);
        send_item(ACTION_QUERY, 8'h01);
    endtask

    // Empty and full transactions, single items and alternating patterns.
    task automatic test_directed_items();
        send_item(ACTION_ADD, 8'h00);
        sender_gap();
        send_item(ACTION_ADD, 8'hFF);
        send_item(ACTION_ADD, 8'h01);
        sender_gap();
        send_item(ACTION_ADD, 8'h80);
        send_item(ACTION_ADD, 8'hAA);
        send_item(ACTION_ADD, 8'h55);
        sender_gap();
        send_item(ACTION_QUERY, 8'h00);
        send_item(ACTION_QUERY, 8'hFF);
        send_item(ACTION_QUERY, 8'h01);
        sender_gap();
        send_item(ACTION_QUERY, 8'h80);
        send_item(ACTION_QUERY, 8'h03);
        send_item(ACTION_QUERY, 8'hAA);
        send_item(ACTION_QUERY, 8'h55);
        send_item(ACTION_QUERY, 8'h81);
    endtask

    // Threshold of zero flags everything, even the empty itemset; the largest
    // threshold flags nothing that has not saturated.
    task automatic test_min_support_extremes();
        settle_block();
        write_min_support(16'd0);
        send_item(ACTION_QUERY, 8'h00);
        send_item(ACTION_QUERY, 8'h7E);
        settle_block();
        write_min_support(16'hFFFF);
        send_item(ACTION_QUERY, 8'h01);
        settle_block();
        write_min_support(16'd1);
        send_item(ACTION_QUERY, 8'h00);
        send_item(ACTION_QUERY, 8'h01);
    endtask

    // The receiver holds off for a long stretch while queries keep coming, so
    // the output register fills and the block stops taking new transactions.
    task automatic test_back_pressure();
        settle_block();
        write_min_support(16'd2);
        tx_idle_enable    = 1'b0;
        long_hold_request = 1'b1;
        send_item(ACTION_QUERY, 8'h01);
        send_item(ACTION_ADD,   8'h03);
        send_item(ACTION_QUERY, 8'h03);
        send_item(ACTION_QUERY, 8'h02);
        send_item(ACTION_ADD,   8'h0F);
        send_item(ACTION_QUERY, 8'h0F);
        send_item(ACTION_QUERY, 8'h01);
        send_item(ACTION_QUERY, 8'h08);
        tx_idle_enable = 1'b1;
    endtask

    // Adds one itemset many times back to back, then checks its count against
    // a threshold equal to it and one just above it.
    task automatic test_repeated_adds();
        settle_block();
        write_min_support(16'hFFFF);
        tx_idle_enable = 1'b0;
        rx_idle_enable = 1'b0;
        for (int i = 0; i < REPEAT_ADDS; i++) begin
            send_item(ACTION_ADD, 8'h40);
        end
        send_item(ACTION_QUERY, 8'h40);
        send_item(ACTION_QUERY, 8'hC0);
        send_item(ACTION_ADD,   8'h40);
        send_item(ACTION_QUERY, 8'h40);
        settle_block();
        write_min_support(CFG_W'(support_mirror[8'h40]));
        send_item(ACTION_QUERY, 8'h40);
        settle_block();
        write_min_support(CFG_W'(support_mirror[8'h40]) + CFG_W'(1));
        send_item(ACTION_QUERY, 8'h40);
        tx_idle_enable = 1'b1;
        rx_idle_enable = 1'b1;
    endtask

    // Mixed adds and queries in phases with different thresholds. Most queries
    // ask for a subset of a recent transaction so that counts build up.
    task automatic test_random_traffic();
        logic [MASK_IN_W-1:0] mask;
        logic [CFG_W-1:0]     threshold;
        int                   items_in_phase;
        for (int phase = 0; phase < 4; phase++) begin
            settle_block();
            case (phase)
                0: threshold = CFG_W'($urandom_range(1, 4));
                1: threshold = CFG_W'($urandom_range(1, 30));
                2: threshold = CFG_W'($urandom_range(1, 65535));
                default: threshold = CFG_W'($urandom_range(2, 12));
            endcase
            write_min_support(threshold);
            if (phase == 3) begin
                // The closing phase runs at full rate on both sides.
                tx_idle_enable = 1'b0;
                rx_idle_enable = 1'b0;
            end
            items_in_phase = (phase == 3) ? 300 : 350;
            for (int i = 0; i < items_in_phase; i++) begin
                if ($urandom_range(0, 9) < 6) begin
                    mask = pick_add_mask();
                    recent_add_masks[$urandom_range(0, 7)] = mask;
                    send_item(ACTION_ADD, mask);
                end else begin
                    if ($urandom_range(0, 3) != 0) begin
                        mask = recent_add_masks[$urandom_range(0, 7)] & MASK_IN_W'($urandom);
                    end else begin
                        mask = MASK_IN_W'($urandom);
                    end
                    send_item(ACTION_QUERY, mask);
                end
                sender_gap();
            end
        end
    endtask

    // Receiver: random short stalls, plus one long hold-off on request.
    initial begin
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        m_ready    = 1'b1;
        forever begin
            @(negedge aclk);
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (rx_idle_enable && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result count=%0d frequent=%0b",
                                          m_data.support_count, m_data.frequent));
            end else begin
                want = expected_results.pop_front();
                if (m_data.support_count !== want.support_count) begin
                    report_mismatch($sformatf("support_count got %0d expected %0d",
                                              m_data.support_count, want.support_count));
                end
                if (m_data.frequent !== want.frequent) begin
                    report_mismatch($sformatf("frequent got %0b expected %0b (count %0d)",
                                              m_data.frequent, want.frequent,
                                              want.support_count));
                end
            end
        end
    end

    // Watchdog: any accepted transaction on any channel restarts the count.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d quiet cycles", quiet_cycles);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_data             = '0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        error_count        = 0;
        quiet_cycles       = 0;
        tx_idle_enable     = 1'b1;
        rx_idle_enable     = 1'b1;
        long_hold_request  = 1'b0;
        min_support_mirror = MIN_SUPPORT_RESET;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            support_mirror[i] = '0;
        end
        for (int i = 0; i < 8; i++) begin
            recent_add_masks[i] = '0;
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_directed_items();
        test_min_support_extremes();
        test_back_pressure();
        test_repeated_adds();
        test_random_traffic();
        settle_block();

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
